// ===== hw/rtl/srsw_pkg.sv =====
// Package for the selective-repeat sender window: shared constants and codes.
// No dependencies; imported by the top level.
package srsw_pkg;

    localparam int MAX_PACKETS_DEF = 1024;
    localparam int MAX_WINDOW_DEF  = 32;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd100;

    // register reset values
    localparam logic [10:0] TOTAL_RST  = 11'd1;
    localparam logic [5:0]  WINDOW_RST = 6'd16;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [15:0] LIMIT_RST  = 16'd1000;

    // register indexes
    localparam logic [1:0] CFG_TOTAL   = 2'd0;
    localparam logic [1:0] CFG_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_LIMIT   = 2'd3;

    // input modes
    localparam logic [1:0] MODE_SCAN   = 2'd0;
    localparam logic [1:0] MODE_ACK    = 2'd1;
    localparam logic [1:0] MODE_DONE   = 2'd2;
    localparam logic [1:0] MODE_BEGIN  = 2'd3;

    // result kinds
    localparam logic [2:0] K_SEND    = 3'd0;
    localparam logic [2:0] K_IDLE    = 3'd1;
    localparam logic [2:0] K_ACK     = 3'd2;
    localparam logic [2:0] K_DONE    = 3'd3;
    localparam logic [2:0] K_ABORT   = 3'd4;
    localparam logic [2:0] K_IGNORED = 3'd5;

endpackage

// ===== hw/rtl/srsw_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module srsw_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/selective_repeat_sender_window.sv =====
// Selective-repeat sender window, top level.
// Depends on srsw_pkg and srsw_ram (acked marks; sent marks with send times).
//
// Usage
//   Input channel (in_valid/in_stall): one transaction carries mode, now_ms,
//   byte_index, ack_bits and last_byte. Output channel (out_valid/out_stall):
//   one transaction per result; last marks the final result of an item.
//   Config port (cfg_we/cfg_index/cfg_data): user writes only while idle, unenforced.
// Item handling
//   Items are handled one at a time. A scan reads each packet between base
//   and window end in S_SREAD and evaluates it in S_SEVAL; a scan answered
//   at once (end, abort) goes straight to its single result. An ack byte
//   writes its eight bits in S_ACKW; with last_byte the base then slides
//   over acked packets in S_SLREAD/S_SLEVAL. Complete-ack goes straight to
//   its single result. Begin-transfer sweeps both RAMs, one entry a cycle.
// Reset
//   After reset the block runs the same sweep with in_stall high; no
//   result is produced by it.
// Back-pressure
//   Results sit in an output register; while out_stall is high the engine
//   simply waits at its next result, nothing is dropped. A new item can be
//   taken while the last result of the previous one still waits.
module selective_repeat_sender_window
    import srsw_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] now_ms,
    input  logic [6:0]  byte_index,
    input  logic [7:0]  ack_bits,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [9:0]  packet_index,
    output logic        is_retransmit,
    output logic [10:0] window_base,
    output logic [15:0] retransmit_count,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(MAX_PACKETS);
    localparam int CW = $clog2(MAX_PACKETS + 1);
    localparam int SW = CW + 8;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_SREAD  = 4'd3;
    localparam logic [3:0] S_SEVAL  = 4'd4;
    localparam logic [3:0] S_SEND   = 4'd5;
    localparam logic [3:0] S_ACKW   = 4'd6;
    localparam logic [3:0] S_SLREAD = 4'd7;
    localparam logic [3:0] S_SLEVAL = 4'd8;
    localparam logic [3:0] S_SINGLE = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [10:0]   total_reg;
    logic [5:0]    window_reg;
    logic [15:0]   timeout_reg;
    logic [15:0]   limit_reg;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] next_reg, next_next;
    logic [15:0]   retx_reg, retx_next;
    logic          fin_reg, fin_next;
    logic          abt_reg, abt_next;
    logic [31:0]   now_reg;
    logic [6:0]    idx_reg;
    logic [7:0]    bits_reg;
    logic          lastb_reg;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] end_reg, end_next;
    logic [2:0]    k_reg, k_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          clr_resp_reg, clr_resp_next;
    logic [2:0]    skind_reg, skind_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pidx_reg, pidx_next;
    logic          prt_reg, prt_next;
    logic [15:0]   pcnt_reg, pcnt_next;

    logic          out_valid_reg;
    logic [2:0]    kind_reg;
    logic [9:0]    pkt_reg;
    logic          rt_reg;
    logic [10:0]   wbase_reg;
    logic [15:0]   cnt_reg;
    logic          last_reg;

    // emission bus into the output register
    logic          emit;
    logic [2:0]    e_kind;
    logic [CW-1:0] e_idx;
    logic          e_rt;
    logic [15:0]   e_cnt;
    logic          e_last;
    logic          can_emit;

    // RAM ports
    logic          a_we, a_rdata, a_wdata;
    logic [AW-1:0] a_waddr, raddr;
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [32:0]   s_wdata, s_rdata;

    logic [CW-1:0] total;
    logic [6:0]    win;
    logic [SW-1:0] win_end;
    logic [15:0]   rto;
    logic          accept;
    logic          due;
    logic [9:0]    ack_p;

    srsw_ram #(.WIDTH(1), .DEPTH(MAX_PACKETS), .AW(AW)) u_acked (
        .clk  (clk),
        .we   (a_we),
        .waddr(a_waddr),
        .wdata(a_wdata),
        .raddr(raddr),
        .rdata(a_rdata)
    );

    // {sent mark, send time}
    srsw_ram #(.WIDTH(33), .DEPTH(MAX_PACKETS), .AW(AW)) u_sent (
        .clk  (clk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .raddr(raddr),
        .rdata(s_rdata)
    );

    // effective limits
    assign total = (32'(total_reg) > 32'(MAX_PACKETS)) ? CW'(MAX_PACKETS) : CW'(total_reg);
    assign win   = (32'(window_reg) > 32'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : 7'(window_reg);
    assign rto   = (timeout_reg == 16'd0) ? DEFAULT_TIMEOUT : timeout_reg;
    assign win_end = SW'(base_reg) + SW'(win);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign can_emit = !out_valid_reg || !out_stall;

    // slide reads at the base, scan reads at the cursor
    assign raddr = ((state_reg == S_SLREAD) || (state_reg == S_SLEVAL))
                   ? base_reg[AW-1:0] : i_reg[AW-1:0];

    // packet is due unless acked, or sent and still inside its timeout
    assign due = !a_rdata && !(s_rdata[32] && ((now_reg - s_rdata[31:0]) < 32'(rto)));

    assign ack_p = {idx_reg, k_reg};

    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        next_next     = next_reg;
        retx_next     = retx_reg;
        fin_next      = fin_reg;
        abt_next      = abt_reg;
        i_next        = i_reg;
        end_next      = end_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        clr_resp_next = clr_resp_reg;
        skind_next    = skind_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        prt_next      = prt_reg;
        pcnt_next     = pcnt_reg;
        emit   = 1'b0;
        e_kind = K_IDLE;
        e_idx  = '0;
        e_rt   = 1'b0;
        e_cnt  = retx_reg;
        e_last = 1'b1;
        a_we    = 1'b0;
        a_waddr = AW'(ack_p);
        a_wdata = 1'b1;
        s_we    = 1'b0;
        s_waddr = i_reg[AW-1:0];
        s_wdata = {1'b1, now_reg};

        case (state_reg)
            S_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_reg;
                a_wdata = 1'b0;
                s_we    = 1'b1;
                s_waddr = clr_reg;
                s_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(MAX_PACKETS - 1))
                begin
                    state_next = clr_resp_reg ? S_SINGLE : S_IDLE;
                    skind_next = K_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_SCAN:
                        begin
                            state_next = S_DECIDE;
                        end
                        MODE_ACK:
                        begin
                            k_next = '0;
                            if (fin_reg || abt_reg)
                            begin
                                skind_next = K_IGNORED;
                                state_next = S_SINGLE;
                            end
                            else
                            begin
                                state_next = S_ACKW;
                            end
                        end
                        MODE_DONE:
                        begin
                            state_next = S_SINGLE;
                            if (fin_reg || abt_reg)
                            begin
                                skind_next = K_IGNORED;
                            end
                            else
                            begin
                                base_next  = total;
                                fin_next   = 1'b1;
                                skind_next = K_DONE;
                            end
                        end
                        default:
                        begin
                            base_next     = '0;
                            next_next     = '0;
                            retx_next     = '0;
                            fin_next      = 1'b0;
                            abt_next      = 1'b0;
                            clr_next      = '0;
                            clr_resp_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    endcase
                end
            end
            S_DECIDE:
            begin
                state_next = S_SINGLE;
                if (abt_reg)
                begin
                    skind_next = K_ABORT;
                end
                else if (fin_reg)
                begin
                    skind_next = K_DONE;
                end
                else if (retx_reg >= limit_reg)
                begin
                    abt_next   = 1'b1;
                    skind_next = K_ABORT;
                end
                else if (base_reg >= total)
                begin
                    fin_next   = 1'b1;
                    skind_next = K_DONE;
                end
                else
                begin
                    i_next     = base_reg;
                    end_next   = (win_end > SW'(total)) ? total : CW'(win_end);
                    pend_next  = 1'b0;
                    state_next = S_SREAD;
                end
            end
            S_SREAD:
            begin
                // read at i_reg issued here, data valid in S_SEVAL
                state_next = (i_reg >= end_reg) ? S_SEND : S_SEVAL;
            end
            S_SEVAL:
            begin
                if (!due)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SREAD;
                end
                else if (!pend_reg || can_emit)
                begin
                    // flush the held send request, it is not the last one
                    if (pend_reg)
                    begin
                        emit   = 1'b1;
                        e_kind = K_SEND;
                        e_idx  = pidx_reg;
                        e_rt   = prt_reg;
                        e_cnt  = pcnt_reg;
                        e_last = 1'b0;
                    end
                    s_we      = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = i_reg;
                    if (i_reg >= next_reg)
                    begin
                        next_next = i_reg + 1'b1;
                        prt_next  = 1'b0;
                        pcnt_next = retx_reg;
                    end
                    else
                    begin
                        prt_next = 1'b1;
                        if (retx_reg < limit_reg)
                        begin
                            retx_next = retx_reg + 1'b1;
                        end
                        pcnt_next = (retx_reg < limit_reg) ? retx_reg + 1'b1 : retx_reg;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_SREAD;
                end
            end
            S_SEND:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (pend_reg)
                    begin
                        e_kind = K_SEND;
                        e_idx  = pidx_reg;
                        e_rt   = prt_reg;
                        e_cnt  = pcnt_reg;
                    end
                    if (retx_reg >= limit_reg)
                    begin
                        abt_next = 1'b1;
                    end
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_ACKW:
            begin
                a_we   = bits_reg[k_reg] && (32'(ack_p) < 32'(total));
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd7)
                begin
                    skind_next = K_ACK;
                    state_next = lastb_reg ? S_SLREAD : S_SINGLE;
                end
            end
            S_SLREAD:
            begin
                state_next = (base_reg < total) ? S_SLEVAL : S_SINGLE;
            end
            S_SLEVAL:
            begin
                if (a_rdata)
                begin
                    base_next  = base_reg + 1'b1;
                    state_next = S_SLREAD;
                end
                else
                begin
                    state_next = S_SINGLE;
                end
            end
            S_SINGLE:
            begin
                if (can_emit)
                begin
                    emit          = 1'b1;
                    e_kind        = skind_reg;
                    clr_resp_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            total_reg     <= TOTAL_RST;
            window_reg    <= WINDOW_RST;
            timeout_reg   <= TIMEOUT_RST;
            limit_reg     <= LIMIT_RST;
            base_reg      <= '0;
            next_reg      <= '0;
            retx_reg      <= '0;
            fin_reg       <= 1'b0;
            abt_reg       <= 1'b0;
            clr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            next_reg     <= next_next;
            retx_reg     <= retx_next;
            fin_reg      <= fin_next;
            abt_reg      <= abt_next;
            clr_reg      <= clr_next;
            clr_resp_reg <= clr_resp_next;
            pend_reg     <= pend_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TOTAL:   total_reg   <= cfg_data[10:0];
                    CFG_WINDOW:  window_reg  <= cfg_data[5:0];
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    CFG_LIMIT:   limit_reg   <= cfg_data;
                    default:     limit_reg   <= limit_reg;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg   <= now_ms;
            idx_reg   <= byte_index;
            bits_reg  <= ack_bits;
            lastb_reg <= last_byte;
        end
        i_reg     <= i_next;
        end_reg   <= end_next;
        k_reg     <= k_next;
        skind_reg <= skind_next;
        pidx_reg  <= pidx_next;
        prt_reg   <= prt_next;
        pcnt_reg  <= pcnt_next;
        if (emit)
        begin
            kind_reg  <= e_kind;
            pkt_reg   <= 10'(e_idx);
            rt_reg    <= e_rt;
            wbase_reg <= 11'(base_reg);
            cnt_reg   <= e_cnt;
            last_reg  <= e_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign packet_index     = pkt_reg;
    assign is_retransmit    = rt_reg;
    assign window_base      = wbase_reg;
    assign retransmit_count = cnt_reg;
    assign last             = last_reg;

    // no RAM writes while waiting for an item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!a_we && !s_we))
        else $error("RAM write while idle");

    // scan cursor never passes the window end
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEVAL) |-> (i_reg < end_reg))
        else $error("scan cursor beyond window end");

    // a held send request only lives inside a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SREAD || state_reg == S_SEVAL || state_reg == S_SEND))
        else $error("held send request outside a scan");

    // sweep after reset or begin-transfer keeps the input closed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input open during sweep");

endmodule

// ===== tb/selective_repeat_sender_window_test.sv =====
// Self-checking bench for the selective-repeat sender window.
// Depends on srsw_pkg and the RTL top level; the window behaviour is modelled
// inside and every result transaction is checked in order.
module selective_repeat_sender_window_test
    import srsw_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPKT      = 1024;
    localparam int NWIN      = 32;
    localparam int CYC_LIMIT = 3000000;
    localparam int SETTLE    = 100;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [6:0]  byte_index;
        logic [7:0]  ack_bits;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [9:0]  packet_index;
        logic        is_retransmit;
        logic [10:0] window_base;
        logic [15:0] retransmit_count;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [6:0]  byte_index;
    logic [7:0]  ack_bits;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [9:0]  packet_index;
    logic        is_retransmit;
    logic [10:0] window_base;
    logic [15:0] retransmit_count;
    logic        last;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    selective_repeat_sender_window dut (.*);

    // Stimulus queue (filled by the sequencer) and expected results queue.
    item_t   pending_items[$];
    result_t due_results[$];
    item_t   held_item;
    int      sender_idle_pct;
    int      recv_stall_pct;
    int      errors;
    int      cycles;

    // Shadow of the block: registers and transfer state.
    logic [10:0] sh_total;
    logic [5:0]  sh_window;
    logic [15:0] sh_timeout;
    logic [15:0] sh_limit;
    bit          acked[NPKT];
    bit          sent[NPKT];
    logic [31:0] sent_at[NPKT];
    int unsigned base_pkt;
    int unsigned next_new;
    int unsigned rtx_count;
    bit          finished;
    bit          aborted;

    // Sequencer-side guess of the clock, advanced before each regular random-traffic scan.
    logic [31:0] clock_ms;

    function automatic int unsigned total_eff();
        return (sh_total > NPKT) ? NPKT : sh_total;
    endfunction

    function automatic result_t make_result(logic [2:0] k, int unsigned idx, bit rt);
        result_t r;
        r.kind             = k;
        r.packet_index     = idx[9:0];
        r.is_retransmit    = rt;
        r.window_base      = base_pkt[10:0];
        r.retransmit_count = rtx_count[15:0];
        r.last             = 1'b0;
        return r;
    endfunction

    task automatic push_single(logic [2:0] k);
        result_t r;
        r      = make_result(k, 0, 1'b0);
        r.last = 1'b1;
        due_results.push_back(r);
    endtask

    task automatic clear_transfer();
        for (int i = 0; i < NPKT; i++)
        begin
            acked[i] = 1'b0;
            sent[i]  = 1'b0;
        end
        base_pkt  = 0;
        next_new  = 0;
        rtx_count = 0;
        finished  = 1'b0;
        aborted   = 1'b0;
    endtask

    // Works out the results of one accepted item and updates the shadow.
    task automatic predict_window_step(item_t it);
        int unsigned tot;
        int unsigned win;
        int unsigned rto;
        int unsigned stop;
        int unsigned p;
        bit          rt;
        result_t     batch[$];
        result_t     r;
        tot = total_eff();
        case (it.mode)
            MODE_SCAN:
            begin
                win = (sh_window > NWIN) ? NWIN : sh_window;
                rto = (sh_timeout == 0) ? DEFAULT_TIMEOUT : sh_timeout;
                if (aborted)
                    push_single(K_ABORT);
                else if (finished)
                    push_single(K_DONE);
                else if (rtx_count >= sh_limit)
                begin
                    aborted = 1'b1;
                    push_single(K_ABORT);
                end
                else if (base_pkt >= tot)
                begin
                    finished = 1'b1;
                    push_single(K_DONE);
                end
                else
                begin
                    stop = base_pkt + win;
                    if (stop > tot)
                        stop = tot;
                    for (int unsigned i = base_pkt; i < stop; i++)
                    begin
                        rt = 1'b0;
                        if (acked[i])
                            continue;
                        if (sent[i] && ((it.now_ms - sent_at[i]) < rto))
                            continue;
                        sent_at[i] = it.now_ms;
                        sent[i]    = 1'b1;
                        if (i >= next_new)
                            next_new = i + 1;
                        else
                        begin
                            rt = 1'b1;
                            if (rtx_count < sh_limit)
                                rtx_count++;
                        end
                        batch.push_back(make_result(K_SEND, i, rt));
                    end
                    if (rtx_count >= sh_limit)
                        aborted = 1'b1;
                    if (batch.size() == 0)
                        push_single(K_IDLE);
                    else
                    begin
                        batch[batch.size()-1].last = 1'b1;
                        foreach (batch[j])
                            due_results.push_back(batch[j]);
                    end
                end
            end
            MODE_ACK:
            begin
                if (finished || aborted)
                    push_single(K_IGNORED);
                else
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        p = it.byte_index * 8 + k;
                        if (it.ack_bits[k] && p < tot)
                            acked[p] = 1'b1;
                    end
                    if (it.last_byte)
                        while (base_pkt < tot && acked[base_pkt])
                            base_pkt++;
                    push_single(K_ACK);
                end
            end
            MODE_DONE:
            begin
                if (finished || aborted)
                    push_single(K_IGNORED);
                else
                begin
                    base_pkt = tot;
                    finished = 1'b1;
                    push_single(K_DONE);
                end
            end
            default:
            begin
                clear_transfer();
                push_single(K_IDLE);
            end
        endcase
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle counter doubles as the watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: on an accepted transaction the shadow is stepped, then the next
    // item (or an idle gap) is presented. in_valid gets at most one assignment a step.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_window_step(held_item);
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    held_item   = pending_items.pop_front();
                    mode       <= held_item.mode;
                    now_ms     <= held_item.now_ms;
                    byte_index <= held_item.byte_index;
                    ack_bits   <= held_item.ack_bits;
                    last_byte  <= held_item.last_byte;
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: every accepted result transaction is checked against the
    // oldest expectation, then the stall for the next edge is chosen.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d packet %0d", kind, packet_index);
                errors++;
            end
            else
            begin
                e = due_results.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, kind);
                    errors++;
                end
                if (packet_index !== e.packet_index)
                begin
                    $error("packet_index: expected %0d, got %0d", e.packet_index, packet_index);
                    errors++;
                end
                if (is_retransmit !== e.is_retransmit)
                begin
                    $error("is_retransmit: expected %0d, got %0d", e.is_retransmit,
                           is_retransmit);
                    errors++;
                end
                if (window_base !== e.window_base)
                begin
                    $error("window_base: expected %0d, got %0d", e.window_base, window_base);
                    errors++;
                end
                if (retransmit_count !== e.retransmit_count)
                begin
                    $error("retransmit_count: expected %0d, got %0d", e.retransmit_count,
                           retransmit_count);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    errors++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic add_item(logic [1:0] m, logic [31:0] t, logic [6:0] bi, logic [7:0] bits,
                            logic lb);
        item_t it;
        it.mode       = m;
        it.now_ms     = t;
        it.byte_index = bi;
        it.ack_bits   = bits;
        it.last_byte  = lb;
        pending_items.push_back(it);
    endtask

    task automatic scan_at(logic [31:0] t);
        add_item(MODE_SCAN, t, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    endtask

    // Noise item of the given mode with random other fields.
    task automatic noise_item(logic [1:0] m);
        add_item(m, $urandom, 7'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Idle: nothing queued, nothing on the wire, nothing outstanding, plus a
    // margin for the engine to settle.
    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || due_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TOTAL:   sh_total   = val[10:0];
            CFG_WINDOW:  sh_window  = val[5:0];
            CFG_TIMEOUT: sh_timeout = val;
            default:     sh_limit   = val;
        endcase
    endtask

    task automatic configure(logic [15:0] tot, logic [15:0] win, logic [15:0] tmo,
                             logic [15:0] lim);
        wait_idle();
        write_reg(CFG_TOTAL, tot);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_LIMIT, lim);
    endtask

    // Mostly well-formed traffic: scans with a moving clock and acks of bytes
    // across the transfer; rare completes, restarts and wild noise items.
    task automatic random_traffic(int n);
        int unsigned rto;
        int unsigned tot;
        int unsigned nbytes;
        int          r;
        rto    = (sh_timeout == 0) ? DEFAULT_TIMEOUT : sh_timeout;
        tot    = total_eff();
        nbytes = (tot + 7) / 8;
        noise_item(MODE_BEGIN);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                clock_ms += $urandom_range(0, 2 * rto + 2);
                scan_at(clock_ms);
            end
            else if (r < 87)
                add_item(MODE_ACK, $urandom,
                         (nbytes > 0) ? 7'($urandom_range(0, nbytes)) : 7'd0,
                         8'($urandom_range(0, 255)), $urandom_range(0, 99) < 60);
            else if (r < 91)
                add_item(MODE_ACK, $urandom, 7'($urandom_range(0, 127)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (r < 94)
            begin
                noise_item(MODE_DONE);
                noise_item(MODE_BEGIN);
            end
            else if (r < 96)
                noise_item(MODE_BEGIN);
            else
                scan_at($urandom);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_SCAN;
        now_ms          = '0;
        byte_index      = '0;
        ack_bits        = '0;
        last_byte       = 1'b0;
        out_stall       = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_TOTAL;
        cfg_data        = '0;
        errors          = 0;
        cycles          = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        sh_total        = TOTAL_RST;
        sh_window       = WINDOW_RST;
        sh_timeout      = TIMEOUT_RST;
        sh_limit        = LIMIT_RST;
        clear_transfer();
        clock_ms        = 32'hFFFF_FF00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset registers: first send, nothing due, retransmit
        // across the clock wrap, ack and slide, then everything after the end.
        scan_at(32'hFFFF_FFC0);
        scan_at(32'hFFFF_FFC0);
        scan_at(32'h0000_0024);
        add_item(MODE_ACK, 32'd0, 7'd0, 8'hFF, 1'b1);
        scan_at(32'h0000_0030);
        scan_at(32'hFFFF_FFFF);
        add_item(MODE_ACK, 32'd0, 7'h7F, 8'h00, 1'b0);
        add_item(MODE_DONE, 32'd0, 7'd0, 8'd0, 1'b0);
        add_item(MODE_BEGIN, 32'd0, 7'd0, 8'd0, 1'b0);
        add_item(MODE_ACK, 32'd0, 7'd1, 8'h01, 1'b0);
        add_item(MODE_DONE, 32'd0, 7'd0, 8'd0, 1'b0);
        add_item(MODE_SCAN, 32'd5, 7'd0, 8'd0, 1'b0);

        // Largest window with zero timeout (acts as default), huge limit.
        configure(16'd40, 16'd32, 16'd0, 16'd65535);
        add_item(MODE_BEGIN, 32'd0, 7'd0, 8'd0, 1'b0);
        scan_at(32'd0);
        add_item(MODE_ACK, 32'd0, 7'd1, 8'hAA, 1'b1);
        add_item(MODE_ACK, 32'd0, 7'd0, 8'hFF, 1'b1);
        scan_at(32'd250);
        random_traffic(60);

        // Oversized transfer and window, longest timeout, tiny limit so the
        // transfer aborts after the scan that reaches it; sender idles heavily.
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5);
        sender_idle_pct = 84;
        random_traffic(60);

        // Zero limit and zero transfer: every scan aborts at once; receiver
        // stalls heavily.
        configure(16'd0, 16'd0, 16'd1, 16'd0);
        sender_idle_pct = 0;
        recv_stall_pct  = 84;
        add_item(MODE_BEGIN, 32'd0, 7'd0, 8'd0, 1'b0);
        scan_at(32'd7);
        scan_at(32'd8);
        random_traffic(25);

        // Empty window: scans find nothing; empty transfer completes at once.
        configure(16'd10, 16'd0, 16'd50, 16'd3);
        random_traffic(25);
        configure(16'd0, 16'd8, 16'd50, 16'd3);
        add_item(MODE_BEGIN, 32'd0, 7'd0, 8'd0, 1'b0);
        scan_at(32'd1);

        // Full transfer size, smallest non-empty window and timeout, both sides idling.
        configure(16'd1024, 16'd1, 16'd1, 16'd1000);
        sender_idle_pct = 18;
        recv_stall_pct  = 18;
        random_traffic(60);

        // Mid-sized setup, no idling at all.
        configure(16'd100, 16'd12, 16'd30, 16'd40);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        random_traffic(60);

        wait_idle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/srsw_pkg.sv
hw/rtl/srsw_ram.sv
hw/rtl/selective_repeat_sender_window.sv
tb/selective_repeat_sender_window_test.sv
